// ----- rtl/ipacl_pkg.sv -----
// ipacl_pkg: shared types, opcodes and status codes for the address/port classifier
// no dependencies
`timescale 1ns / 1ps
package ipacl_pkg;

   localparam int TableDepthDefault = 64;

   typedef enum logic [1:0] {
      OP_CLASSIFY = 2'd0,
      OP_ADD      = 2'd1,
      OP_DELETE   = 2'd2,
      OP_CLEAR    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ABSENT  = 2'd1,
      ST_INVALID = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   localparam logic [1:0] SIDE_NONE = 2'd0;
   localparam logic [1:0] SIDE_DST  = 2'd1;
   localparam logic [1:0] SIDE_SRC  = 2'd2;

   // item that enters the cell chain
   typedef struct packed {
      logic        rev;
      logic        srv;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic [31:0] dst_addr;
      logic [15:0] dst_port;
      logic [31:0] key_addr;
      logic [5:0]  key_prefix;
      logic [15:0] key_port;
   } query_type;

   // per-cell findings, one bit per check class, plus the side of a subnet hit
   typedef struct packed {
      logic key_hit;
      logic free;
      logic ex_dd;
      logic ex_ss;
      logic ex_sd;
      logic ex_ds;
      logic sub_hit;
      logic [1:0] sub_side;
   } cell_hit_type;

   function automatic logic [31:0] net_mask(input logic [5:0] p);
      logic [31:0] m;
      m = 32'd0;
      if (p >= 6'd32) m = '1;
      else if (p != 6'd0) m = ~(32'hFFFF_FFFF >> p);
      return m;
   endfunction

endpackage

// ----- rtl/ipacl_cell.sv -----
// ipacl_cell: one table slot; compares the broadcast query and reports its
// hits and tag to the chain, which makes the priority pick. depends on ipacl_pkg
`timescale 1ns / 1ps
module ipacl_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ipacl_pkg::query_type    query,
   input  logic                    clear_all,
   input  logic                    write_entry,
   input  logic                    write_tag,
   input  logic                    kill,
   input  logic [15:0]             new_tag,
   output ipacl_pkg::cell_hit_type hit,
   output logic [15:0]             tag
);
   import ipacl_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] addr_ff;
   logic [5:0]  prefix_ff;
   logic [15:0] port_ff;
   logic [15:0] tag_ff;
   logic [31:0] mask;
   logic        dst_in, src_in, exact;

   always_comb begin
      valid_in = valid_ff;
      if (clear_all || kill) valid_in = 1'b0;
      else if (write_entry) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (write_entry) begin
         addr_ff   <= query.key_addr;
         prefix_ff <= query.key_prefix;
         port_ff   <= query.key_port;
      end
      if (write_entry || write_tag) tag_ff <= new_tag;
   end

   always_comb begin
      mask   = net_mask(prefix_ff);
      exact  = valid_ff && (prefix_ff == 6'd0);
      dst_in = (query.dst_addr & mask) == (addr_ff & mask);
      src_in = (query.src_addr & mask) == (addr_ff & mask);
      hit = '0;
      hit.key_hit = valid_ff && prefix_ff == query.key_prefix
                    && addr_ff == query.key_addr && port_ff == query.key_port;
      hit.free  = !valid_ff;
      hit.ex_dd = exact && addr_ff == query.dst_addr && port_ff == query.dst_port;
      hit.ex_ss = exact && addr_ff == query.src_addr && port_ff == query.src_port;
      hit.ex_sd = exact && addr_ff == query.src_addr && port_ff == query.dst_port;
      hit.ex_ds = exact && addr_ff == query.dst_addr && port_ff == query.src_port;
      if (valid_ff && prefix_ff != 6'd0) begin
         if (port_ff == query.dst_port) begin
            if (dst_in || (query.rev && src_in)) begin
               hit.sub_hit  = 1'b1;
               hit.sub_side = SIDE_DST;
            end
         end else if (!query.srv && port_ff == query.src_port) begin
            if (src_in || (query.rev && dst_in)) begin
               hit.sub_hit  = 1'b1;
               hit.sub_side = SIDE_SRC;
            end
         end
      end
   end

   assign tag = tag_ff;

endmodule

// ----- rtl/ipacl_chain.sv -----
// ipacl_chain: row of slot cells with a per-class priority chain, lowest slot first
// depends on ipacl_pkg, ipacl_cell
`timescale 1ns / 1ps
module ipacl_chain #(
   parameter int TableDepth = ipacl_pkg::TableDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ipacl_pkg::query_type   query,
   input  logic                   clear_all,
   input  logic                   do_add,
   input  logic                   do_del,
   input  logic [15:0]            new_tag,
   output logic [6:0]             any_hit,
   output logic [6:0][15:0]       first_tag,
   output logic [1:0]             sub_side
);
   import ipacl_pkg::*;

   // classes: 0 key, 1 free, 2 dd, 3 ss, 4 sd, 5 ds, 6 subnet
   cell_hit_type      hit   [TableDepth];
   logic [15:0]       tags  [TableDepth];
   logic [6:0]        seen  [TableDepth+1];
   logic [6:0][15:0]  pick  [TableDepth+1];
   logic [1:0]        sside [TableDepth+1];
   logic [6:0]        cls   [TableDepth];

   assign seen[0]  = '0;
   assign pick[0]  = '0;
   assign sside[0] = SIDE_NONE;

   for (genvar g = 0; g < TableDepth; g++) begin : g_cell
      logic first_free, first_key;
      assign cls[g] = {hit[g].sub_hit, hit[g].ex_ds, hit[g].ex_sd, hit[g].ex_ss,
                       hit[g].ex_dd, hit[g].free, hit[g].key_hit};
      assign first_free = cls[g][1] && !seen[g][1];
      assign first_key  = cls[g][0] && !seen[g][0];
      ipacl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .query      (query),
         .clear_all  (clear_all),
         .write_entry(do_add && !any_hit[0] && first_free),
         .write_tag  (do_add && first_key),
         .kill       (do_del && first_key),
         .new_tag    (new_tag),
         .hit        (hit[g]),
         .tag        (tags[g])
      );
      always_comb begin
         seen[g+1]  = seen[g] | cls[g];
         pick[g+1]  = pick[g];
         sside[g+1] = sside[g];
         for (int c = 0; c < 7; c++) begin
            if (cls[g][c] && !seen[g][c]) pick[g+1][c] = tags[g];
         end
         if (cls[g][6] && !seen[g][6]) sside[g+1] = hit[g].sub_side;
      end
   end

   assign any_hit   = seen[TableDepth];
   assign first_tag = pick[TableDepth];
   assign sub_side  = sside[TableDepth];

endmodule

// ----- rtl/ip_port_acl_classifier.sv -----
// ip_port_acl_classifier: top level, stream handshake, decode and result register
// depends on ipacl_pkg, ipacl_chain
//
// req channel carries one command item: classify, add, delete or clear.
// rsp channel returns exactly one result item per request, in order.
// csr_we writes reverse_match_enable; write only while the block is idle.
// an item is compared by the slot row against every slot at once, the
// priority chain along the row picks the lowest slot of each check class,
// and the table update and result register load at the same edge. the
// result is valid on the next cycle.
// the result register is a single stage: a new item is taken when it is
// empty or being drained, giving one item per cycle while rsp_tready is high.
// when the receiver stalls, the result holds and req_tready falls.
// reset empties the table and the result register and clears the csr.
// the table holds TableDepth slots, all compared combinationally.
//
`timescale 1ns / 1ps
module ip_port_acl_classifier #(
   parameter int TableDepth = ipacl_pkg::TableDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0], server_side_only[2], src_addr[34:3], src_port[50:35],
   // dst_addr[82:51], dst_port[98:83], entry_addr[130:99],
   // entry_prefix[136:131], entry_port[152:137], entry_tag[168:153], zero fill
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], match_side[3:2], match_tag[19:4], match_is_subnet[20], zero fill
   output logic [23:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_wdata
);
   import ipacl_pkg::*;

   logic        rev_ff;
   logic        valid_ff;
   logic [20:0] out_ff;
   logic [20:0] out_in;
   logic        take;
   opcode_type  op;
   query_type   q;
   logic [31:0] eaddr;
   logic [5:0]  epre;
   logic [15:0] eport, etag;
   logic        bad;
   logic [6:0]        any_hit;
   logic [6:0][15:0]  ftag;
   logic [1:0]        sside;
   status_type  st;
   logic [1:0]  side;
   logic [15:0] mtag;
   logic        msub;

   assign take  = req_tvalid && req_tready;
   assign req_tready = !valid_ff || rsp_tready;
   assign op    = opcode_type'(req_tdata[1:0]);
   assign eaddr = req_tdata[130:99];
   assign epre  = req_tdata[136:131];
   assign eport = req_tdata[152:137];
   assign etag  = req_tdata[168:153];
   assign bad   = eaddr == 32'd0 || eport == 16'd0 || epre > 6'd32;

   always_comb begin
      q = '0;
      q.rev      = rev_ff;
      q.srv      = req_tdata[2];
      q.src_addr = req_tdata[34:3];
      q.src_port = req_tdata[50:35];
      q.dst_addr = req_tdata[82:51];
      q.dst_port = req_tdata[98:83];
      q.key_addr = eaddr & ((epre == 6'd0) ? 32'hFFFF_FFFF : net_mask(epre));
      q.key_prefix = epre;
      q.key_port   = eport;
   end

   ipacl_chain #(.TableDepth(TableDepth)) u_chain (
      .clock    (clock),
      .reset    (reset),
      .query    (q),
      .clear_all(take && op == OP_CLEAR),
      .do_add   (take && op == OP_ADD && !bad),
      .do_del   (take && op == OP_DELETE && !bad),
      .new_tag  (etag),
      .any_hit  (any_hit),
      .first_tag(ftag),
      .sub_side (sside)
   );

   always_comb begin
      st = ST_ABSENT;
      side = SIDE_NONE;
      mtag = 16'd0;
      msub = 1'b0;
      unique case (op)
         OP_CLEAR: st = ST_OK;
         OP_ADD: begin
            if (bad) st = ST_INVALID;
            else if (any_hit[0] || any_hit[1]) st = ST_OK;
            else st = ST_FULL;
         end
         OP_DELETE: begin
            if (bad) st = ST_INVALID;
            else if (any_hit[0]) st = ST_OK;
            else st = ST_ABSENT;
         end
         OP_CLASSIFY: begin
            st = ST_OK;
            priority if (any_hit[2]) begin
               side = SIDE_DST; mtag = ftag[2];
            end else if (!q.srv && any_hit[3]) begin
               side = SIDE_SRC; mtag = ftag[3];
            end else if (rev_ff && any_hit[4]) begin
               side = SIDE_DST; mtag = ftag[4];
            end else if (rev_ff && !q.srv && any_hit[5]) begin
               side = SIDE_SRC; mtag = ftag[5];
            end else if (any_hit[6]) begin
               side = sside; mtag = ftag[6]; msub = 1'b1;
            end else begin
               st = ST_ABSENT;
            end
         end
         default: st = ST_ABSENT;
      endcase
      out_in = {msub, mtag, side, st};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) rev_ff <= csr_wdata;
         if (take) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
      if (take) out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, out_ff};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_no_take_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while result stalled");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("item taken without result");

endmodule
